// ===== rtl/tccw_pkg.sv =====
`default_nettype none

package tccw_pkg;

	typedef enum logic [1:0] {
		FUNC_PUT   = 2'd0,
		FUNC_CLEAR = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CMD,
		ST_SC_RD,
		ST_SC_WR,
		ST_FILL,
		ST_RD,
		ST_DONE
	} state_t;

	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_LF         = 8'h0A;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_PRINT_LAST = 8'h7E;
	localparam logic [7:0] ATTR_RESET    = 8'h07;

endpackage

`default_nettype wire

// ===== rtl/tccw_cmd_if.sv =====
`default_nettype none

interface tccw_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [7:0]  ch;
	logic [7:0]  attr;
	logic [10:0] cell_index;

	modport source (output valid, func, ch, attr, cell_index, input ready);
	modport sink (input valid, func, ch, attr, cell_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/tccw_rsp_if.sv =====
`default_nettype none

interface tccw_rsp_if;
	logic        valid;
	logic        ready;
	logic [10:0] cursor_pos;
	logic [7:0]  cell_char;
	logic [7:0]  cell_attr;

	modport source (output valid, cursor_pos, cell_char, cell_attr, input ready);
	modport sink (input valid, cursor_pos, cell_char, cell_attr, output ready);
endinterface

`default_nettype wire

// ===== rtl/tccw_cell_ram.sv =====
`default_nettype none

module tccw_cell_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] wa,
	input  wire logic [15:0]   wd,
	input  wire logic          re,
	input  wire logic [AW-1:0] ra,
	output logic [15:0]        rd
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd <= mem[ra];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/text_console_char_writer.sv =====
// A command is accepted in ST_IDLE, handled in ST_CMD and ends in ST_DONE, which holds until
// the response register is free. An in-range read also passes ST_RD, as the cell store has a
// registered read port. A scroll copies each moved cell via ST_SC_RD and ST_SC_WR, then
// fills the bottom row in ST_FILL; a clear fills every cell in ST_FILL. One command is in
// flight at a time; the next is taken once the result is registered. After reset the
// store is swept to blank cells, one cell per cycle, and no command is taken until the sweep ends.
`default_nettype none

module text_console_char_writer
	import tccw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input wire logic   clk,
	input wire logic   arst_n,
	tccw_cmd_if.sink   cmd,
	tccw_rsp_if.source rsp
);

	localparam int NCELLS     = COLUMNS * ROWS;
	localparam int AW         = $clog2(NCELLS);
	localparam int CW         = $clog2(COLUMNS);
	localparam int RW         = $clog2(ROWS);
	localparam int SCROLL_POS = (ROWS - 1) * COLUMNS;

	state_t          state_q, state_d;
	logic [AW-1:0]   ptr_q, ptr_d;
	logic [CW-1:0]   col_q, col_d;
	logic [RW-1:0]   row_q, row_d;
	logic [AW-1:0]   pos_q, pos_d;
	func_t           func_q;
	logic [7:0]      ch_q;
	logic [7:0]      attr_q;
	logic [10:0]     idx_q;
	logic [7:0]      res_char_q;
	logic [7:0]      res_attr_q;
	logic            out_valid_q;
	logic [10:0]     out_pos_q;
	logic [7:0]      out_char_q;
	logic [7:0]      out_attr_q;

	logic            mem_we;
	logic [AW-1:0]   mem_wa;
	logic [15:0]     mem_wd;
	logic            mem_re;
	logic [AW-1:0]   mem_ra;
	logic [15:0]     mem_rd;

	logic            is_print;
	logic            is_cr;
	logic            is_lf;
	logic            last_col;
	logic            last_row;
	logic            newline;
	logic            idx_ok;
	logic            ptr_last;
	logic            copy_last;
	logic            out_free;
	logic [7:0]      fill_attr;

	tccw_cell_ram #(
		.DEPTH(NCELLS),
		.AW   (AW)
	) u_ram (
		.clk(clk),
		.we (mem_we),
		.wa (mem_wa),
		.wd (mem_wd),
		.re (mem_re),
		.ra (mem_ra),
		.rd (mem_rd)
	);

	assign is_print  = (ch_q >= CH_SPACE) && (ch_q <= CH_PRINT_LAST);
	assign is_cr     = (ch_q == CH_CR);
	assign is_lf     = (ch_q == CH_LF);
	assign last_col  = ({1'b0, col_q} + (CW+1)'(1)) == (CW+1)'(COLUMNS);
	assign last_row  = (row_q == RW'(ROWS - 1));
	assign newline   = (is_print && last_col) || is_lf;
	assign idx_ok    = (32'(idx_q) < 32'(NCELLS));
	assign ptr_last  = (ptr_q == AW'(NCELLS - 1));
	assign copy_last = (ptr_q == AW'(NCELLS - COLUMNS - 1));
	assign out_free  = !out_valid_q || rsp.ready;
	assign fill_attr = (state_q == ST_INIT) ? ATTR_RESET : attr_q;

	assign cmd.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.cursor_pos = out_pos_q;
	assign rsp.cell_char  = out_char_q;
	assign rsp.cell_attr  = out_attr_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (ptr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd.valid) begin
					state_d = ST_CMD;
				end
			end
			ST_CMD: begin
				case (func_q)
					FUNC_PUT: begin
						if (newline && last_row) begin
							state_d = ST_SC_RD;
						end else begin
							state_d = ST_DONE;
						end
					end
					FUNC_CLEAR: state_d = ST_FILL;
					FUNC_READ: state_d = idx_ok ? ST_RD : ST_DONE;
					default: state_d = ST_DONE;
				endcase
			end
			ST_SC_RD: state_d = ST_SC_WR;
			ST_SC_WR: begin
				state_d = copy_last ? ST_FILL : ST_SC_RD;
			end
			ST_FILL: begin
				if (ptr_last) begin
					state_d = ST_DONE;
				end
			end
			ST_RD: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = ptr_q;
		mem_wd = {fill_attr, CH_SPACE};
		mem_re = 1'b0;
		mem_ra = AW'(idx_q);
		ptr_d  = ptr_q;
		col_d  = col_q;
		row_d  = row_q;
		pos_d  = pos_q;
		case (state_q)
			ST_INIT, ST_FILL: begin
				mem_we = 1'b1;
				ptr_d  = ptr_q + AW'(1);
			end
			ST_CMD: begin
				case (func_q)
					FUNC_PUT: begin
						if (is_print) begin
							mem_we = 1'b1;
							mem_wa = pos_q;
							mem_wd = {attr_q, ch_q};
						end
						if (newline) begin
							col_d = '0;
							if (last_row) begin
								ptr_d = '0;
								pos_d = AW'(SCROLL_POS);
							end else begin
								row_d = row_q + RW'(1);
								pos_d = pos_q - AW'(col_q) + AW'(COLUMNS);
							end
						end else if (is_print) begin
							col_d = col_q + CW'(1);
							pos_d = pos_q + AW'(1);
						end else if (is_cr) begin
							col_d = '0;
							pos_d = pos_q - AW'(col_q);
						end
					end
					FUNC_CLEAR: begin
						ptr_d = '0;
						col_d = '0;
						row_d = '0;
						pos_d = '0;
					end
					FUNC_READ: begin
						mem_re = idx_ok;
					end
					default: begin
						mem_re = 1'b0;
					end
				endcase
			end
			ST_SC_RD: begin
				mem_re = 1'b1;
				mem_ra = ptr_q + AW'(COLUMNS);
			end
			ST_SC_WR: begin
				mem_we = 1'b1;
				mem_wd = mem_rd;
				ptr_d  = ptr_q + AW'(1);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			ptr_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			col_q   <= col_d;
			row_q   <= row_d;
			pos_q   <= pos_d;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			func_q     <= func_t'(cmd.func);
			ch_q       <= cmd.ch;
			attr_q     <= cmd.attr;
			idx_q      <= cmd.cell_index;
			res_char_q <= '0;
			res_attr_q <= '0;
		end else if (state_q == ST_RD) begin
			res_char_q <= mem_rd[7:0];
			res_attr_q <= mem_rd[15:8];
		end
		if (state_q == ST_DONE && out_free) begin
			out_pos_q  <= 11'(pos_q);
			out_char_q <= res_char_q;
			out_attr_q <= res_attr_q;
		end
	end

endmodule

`default_nettype wire
